@@ design/slotted_page_space_manager_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the slotted page space manager
// Both macros check on the rising edge of clk_i and are off while in reset.
// ---------------------------------------------------------------------------
`ifndef SLOTTED_PAGE_SPACE_MANAGER_ASSERT_SVH
`define SLOTTED_PAGE_SPACE_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every edge outside reset.
`define SPSM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spsm assertion failed");
// The condition must never be seen outside reset.
`define SPSM_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("spsm forbidden condition seen");
`else
`define SPSM_ASSERT(name, prop)
`define SPSM_NEVER(name, cond)
`endif
`endif

@@ design/spsm_pkg.sv @@
// ---------------------------------------------------------------------------
// spsm_pkg
// Page geometry, derived limits, op and status codes and sequencer states of the space manager.
// ---------------------------------------------------------------------------
package spsm_pkg;

  localparam int PAGE_BYTES         = 4096;
  localparam int HEADER_BYTES       = 32;
  localparam int BLOCK_HEADER_BYTES = 8;
  localparam int MAX_SLOTS          = 256;
  localparam int MIN_HOLE_BYTES     = 16;
  localparam int STUB_BYTES         = 64;
  localparam int SLOT_BYTES         = 2;
  localparam int BLOCK_MAX          = (PAGE_BYTES - HEADER_BYTES - 4 * 2) / 4;
  localparam int UNDERFLOW_FREE     = PAGE_BYTES - HEADER_BYTES - (BLOCK_MAX + 2);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADPOS  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_HRD, S_HCHK, S_HLINK, S_GAP, S_CCHK, S_CWR,
    S_SHCHK, S_SHWR, S_ERD, S_ECAP, S_EMCHK, S_EMWR, S_DONE
  } state_e;

endpackage

@@ design/spsm_ram.sv @@
// ---------------------------------------------------------------------------
// spsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module spsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/slotted_page_space_manager.sv @@
// ---------------------------------------------------------------------------
// slotted_page_space_manager
// Block allocator of one slotted page: first-fit hole list, gap, compaction.
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, op/pos/payload    | item into block
//   out     | out_valid_o, out_stall_i, eight result    | item out of block
//
// An item runs from its acceptance through decode and the sequencer states to
// its registered result; the sequencer steps through the slot or hole RAM one
// entry at a time, issuing a read and then using the registered read data.
// No new item is accepted until the block is back in idle after the result.
// Reset clears the page registers to an empty page; the RAMs need no clear.
// A finished result waits in the output register; a new item is accepted
// meanwhile, and the block holds its next result until the output frees up.
// ---------------------------------------------------------------------------
module slotted_page_space_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  pos_i,
  input  logic [15:0] payload_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] block_offset_o,
  output logic [9:0]  block_bytes_o,
  output logic        spilled_o,
  output logic        compacted_o,
  output logic [12:0] free_bytes_o,
  output logic [8:0]  item_count_o,
  output logic        underflow_o
);
  import spsm_pkg::*;
  `include "slotted_page_space_manager_assert.svh"

  state_e      state_q, state_d;
  logic [1:0]  op_q, op_d;
  logic [7:0]  pos_q, pos_d;
  logic [9:0]  sz_q, sz_d;
  logic        spill_q, spill_d, cmp_q, cmp_d;
  logic [1:0]  status_q, status_d;
  logic [11:0] boff_q, boff_d;
  logic [11:0] head_q, head_d;
  logic [12:0] fs_q, fs_d;
  logic [12:0] bf_q, bf_d;
  logic [8:0]  count_q, count_d;
  logic [11:0] h_q, h_d, prev_q, prev_d, link_q, link_d;
  logic        has_prev_q, has_prev_d;
  logic [12:0] steps_q, steps_d, top_q, top_d;
  logic [8:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  o_status_q;
  logic [11:0] o_boff_q;
  logic [9:0]  o_bb_q;
  logic        o_spill_q, o_cmp_q, o_under_q;
  logic [12:0] o_fs_q;
  logic [8:0]  o_count_q;

  logic        s_off_we, s_size_we, h_size_we, h_next_we;
  logic [7:0]  s_waddr, s_raddr;
  logic [11:0] s_off_wdata, s_off_rdata;
  logic [9:0]  s_size_wdata, s_size_rdata;
  logic [11:0] h_waddr, h_raddr, h_size_wdata, h_size_rdata, h_next_wdata, h_next_rdata;

  logic        accept, out_free;
  logic [16:0] real_bytes;
  logic        hole_fits, rest_ok, walk_end, gap_ok;
  logic [11:0] rest_size;
  logic [12:0] rest_addr, top_new;
  logic [14:0] gap_need;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign real_bytes = {1'b0, payload_bytes_i} + 17'(BLOCK_HEADER_BYTES);

  assign hole_fits = (h_size_rdata >= {2'b00, sz_q});
  assign rest_size = h_size_rdata - {2'b00, sz_q};
  assign rest_addr = {1'b0, h_q} + {3'b000, sz_q};
  assign rest_ok   = (rest_size >= 12'(MIN_HOLE_BYTES)) && (rest_addr < 13'(PAGE_BYTES));
  assign walk_end  = (h_next_rdata == 12'd0) || ((steps_q + 13'd1) >= 13'(PAGE_BYTES));
  assign gap_need  = 15'(HEADER_BYTES + SLOT_BYTES) + {5'b0, count_q, 1'b0}
                   + {2'b00, bf_q} + {5'b0, sz_q};
  // The gap must exceed the block plus one more slot.
  assign gap_ok    = gap_need < 15'(PAGE_BYTES);
  assign top_new   = ({3'b000, s_size_rdata} <= top_q) ? top_q - {3'b000, s_size_rdata}
                                                         : 13'd0;

  spsm_ram #(.WIDTH(12), .DEPTH(MAX_SLOTS)) u_slot_off (
    .clk_i, .we_i(s_off_we), .waddr_i(s_waddr), .wdata_i(s_off_wdata),
    .raddr_i(s_raddr), .rdata_o(s_off_rdata));
  spsm_ram #(.WIDTH(10), .DEPTH(MAX_SLOTS)) u_slot_size (
    .clk_i, .we_i(s_size_we), .waddr_i(s_waddr), .wdata_i(s_size_wdata),
    .raddr_i(s_raddr), .rdata_o(s_size_rdata));
  spsm_ram #(.WIDTH(12), .DEPTH(PAGE_BYTES)) u_hole_size (
    .clk_i, .we_i(h_size_we), .waddr_i(h_waddr), .wdata_i(h_size_wdata),
    .raddr_i(h_raddr), .rdata_o(h_size_rdata));
  spsm_ram #(.WIDTH(12), .DEPTH(PAGE_BYTES)) u_hole_next (
    .clk_i, .we_i(h_next_we), .waddr_i(h_waddr), .wdata_i(h_next_wdata),
    .raddr_i(h_raddr), .rdata_o(h_next_rdata));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_DEC;
      S_DEC: begin
        unique case (op_q)
          OP_INSERT: begin
            if (({1'b0, pos_q} > count_q) || (count_q >= 9'(MAX_SLOTS))
                || (fs_q < (13'(sz_q) + 13'(SLOT_BYTES)))) begin
              state_d = S_DONE;
            end else if (head_q == 12'd0) begin
              state_d = S_GAP;
            end else begin
              state_d = S_HRD;
            end
          end
          OP_ERASE: state_d = ({1'b0, pos_q} >= count_q) ? S_DONE : S_ERD;
          default:  state_d = S_DONE;
        endcase
      end
      S_HRD:   state_d = S_HCHK;
      S_HCHK: begin
        if (hole_fits) state_d = S_HLINK;
        else if (walk_end) state_d = S_GAP;
        else state_d = S_HRD;
      end
      S_HLINK: state_d = S_SHCHK;
      S_GAP: begin
        if (gap_ok) state_d = S_SHCHK;
        else if (!cmp_q) state_d = S_CCHK;
        else state_d = S_DONE;
      end
      S_CCHK:  state_d = (idx_q == 9'd0) ? S_GAP : S_CWR;
      S_CWR:   state_d = S_CCHK;
      S_SHCHK: state_d = (idx_q > {1'b0, pos_q}) ? S_SHWR : S_DONE;
      S_SHWR:  state_d = S_SHCHK;
      S_ERD:   state_d = S_ECAP;
      S_ECAP:  state_d = S_EMCHK;
      S_EMCHK: state_d = ((idx_q + 9'd1) < count_q) ? S_EMWR : S_DONE;
      S_EMWR:  state_d = S_EMCHK;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d = op_q; pos_d = pos_q; sz_d = sz_q; spill_d = spill_q; cmp_d = cmp_q;
    status_d = status_q; boff_d = boff_q; head_d = head_q; fs_d = fs_q;
    bf_d = bf_q; count_d = count_q; h_d = h_q; prev_d = prev_q; link_d = link_q;
    has_prev_d = has_prev_q; steps_d = steps_q; top_d = top_q; idx_d = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    s_off_we = 1'b0; s_size_we = 1'b0; h_size_we = 1'b0; h_next_we = 1'b0;
    s_waddr = idx_q[7:0]; s_raddr = idx_q[7:0];
    s_off_wdata = s_off_rdata; s_size_wdata = s_size_rdata;
    h_waddr = rest_addr[11:0]; h_raddr = h_q;
    h_size_wdata = rest_size; h_next_wdata = h_next_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_i; pos_d = pos_i;
          spill_d = (real_bytes > 17'(BLOCK_MAX));
          sz_d = spill_d ? 10'(STUB_BYTES) : real_bytes[9:0];
          cmp_d = 1'b0; status_d = ST_DONE; boff_d = 12'd0;
        end
      end
      S_DEC: begin
        unique case (op_q)
          OP_INSERT: begin
            if ({1'b0, pos_q} > count_q) begin
              status_d = ST_BADPOS; sz_d = 10'd0; spill_d = 1'b0;
            end else if ((count_q >= 9'(MAX_SLOTS))
                         || (fs_q < (13'(sz_q) + 13'(SLOT_BYTES)))) begin
              status_d = ST_NOSPACE;
            end else begin
              h_d = head_q; prev_d = 12'd0; has_prev_d = 1'b0; steps_d = 13'd0;
            end
          end
          OP_ERASE: begin
            sz_d = 10'd0; spill_d = 1'b0;
            if ({1'b0, pos_q} >= count_q) status_d = ST_BADPOS;
          end
          OP_INIT: begin
            sz_d = 10'd0; spill_d = 1'b0;
            head_d = 12'd0; fs_d = 13'(PAGE_BYTES - HEADER_BYTES);
            bf_d = 13'd0; count_d = 9'd0;
          end
          default: begin
            sz_d = 10'd0; spill_d = 1'b0; status_d = ST_BADPOS;
          end
        endcase
      end
      S_HCHK: begin
        if (hole_fits) begin
          // Split off the tail only when it is big enough to be a hole itself.
          if (rest_ok) begin
            h_size_we = 1'b1; h_next_we = 1'b1;
            link_d = rest_addr[11:0];
          end else begin
            link_d = h_next_rdata;
          end
          fs_d = fs_q - 13'(sz_q);
          boff_d = h_q;
        end else if (!walk_end) begin
          steps_d = steps_q + 13'd1;
          prev_d = h_q; has_prev_d = 1'b1; h_d = h_next_rdata;
        end
      end
      S_HLINK: begin
        if (has_prev_q) begin
          h_waddr = prev_q; h_next_wdata = link_q; h_next_we = 1'b1;
        end else begin
          head_d = link_q;
        end
        idx_d = count_q;
      end
      S_GAP: begin
        if (gap_ok) begin
          boff_d = 12'(13'(PAGE_BYTES) - bf_q - 13'(sz_q));
          fs_d = fs_q - 13'(sz_q);
          bf_d = bf_q + 13'(sz_q);
          idx_d = count_q;
        end else if (!cmp_q) begin
          cmp_d = 1'b1; idx_d = count_q; top_d = 13'(PAGE_BYTES);
        end else begin
          status_d = ST_NOSPACE;
        end
      end
      S_CCHK: begin
        if (idx_q == 9'd0) begin
          head_d = 12'd0;
          bf_d = 13'(PAGE_BYTES) - top_q;
        end else begin
          s_raddr = 8'(idx_q - 9'd1);
        end
      end
      S_CWR: begin
        s_waddr = 8'(idx_q - 9'd1);
        s_off_wdata = top_new[11:0]; s_off_we = 1'b1;
        top_d = top_new; idx_d = idx_q - 9'd1;
      end
      S_SHCHK: begin
        if (idx_q > {1'b0, pos_q}) begin
          s_raddr = 8'(idx_q - 9'd1);
        end else begin
          s_waddr = pos_q; s_off_wdata = boff_q; s_size_wdata = sz_q;
          s_off_we = 1'b1; s_size_we = 1'b1;
          fs_d = fs_q - 13'(SLOT_BYTES);
          count_d = count_q + 9'd1;
        end
      end
      S_SHWR: begin
        s_off_we = 1'b1; s_size_we = 1'b1; idx_d = idx_q - 9'd1;
      end
      S_ERD: begin
        s_raddr = pos_q;
      end
      S_ECAP: begin
        boff_d = s_off_rdata; sz_d = s_size_rdata; idx_d = {1'b0, pos_q};
      end
      S_EMCHK: begin
        if ((idx_q + 9'd1) < count_q) begin
          s_raddr = 8'(idx_q + 9'd1);
        end else begin
          fs_d = fs_q + 13'(SLOT_BYTES) + 13'(sz_q);
          count_d = count_q - 9'd1;
          h_waddr = boff_q; h_size_wdata = 12'(sz_q); h_next_wdata = head_q;
          h_size_we = 1'b1; h_next_we = 1'b1;
          head_d = boff_q;
        end
      end
      S_EMWR: begin
        s_off_we = 1'b1; s_size_we = 1'b1; idx_d = idx_q + 9'd1;
      end
      S_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= 12'd0;
      fs_q <= 13'(PAGE_BYTES - HEADER_BYTES);
      bf_q <= 13'd0;
      count_q <= 9'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      fs_q <= fs_d;
      bf_q <= bf_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pos_q <= pos_d; sz_q <= sz_d; spill_q <= spill_d; cmp_q <= cmp_d;
    status_q <= status_d; boff_q <= boff_d; h_q <= h_d; prev_q <= prev_d;
    link_q <= link_d; has_prev_q <= has_prev_d; steps_q <= steps_d;
    top_q <= top_d; idx_q <= idx_d;
    if (state_q == S_DONE && out_free) begin
      o_status_q <= status_q;
      o_boff_q <= boff_q;
      o_bb_q <= sz_q;
      o_spill_q <= spill_q;
      o_cmp_q <= cmp_q;
      o_fs_q <= fs_q;
      o_count_q <= count_q;
      o_under_q <= (fs_q > 13'(UNDERFLOW_FREE));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign block_offset_o = o_boff_q;
  assign block_bytes_o  = o_bb_q;
  assign spilled_o      = o_spill_q;
  assign compacted_o    = o_cmp_q;
  assign free_bytes_o   = o_fs_q;
  assign item_count_o   = o_count_q;
  assign underflow_o    = o_under_q;

  `SPSM_NEVER(a_count_max, count_q > 9'(MAX_SLOTS))
  `SPSM_ASSERT(a_accept_dec, accept |=> state_q == S_DEC)
  `SPSM_NEVER(a_shift_idx, state_q == S_SHWR && idx_q == 9'd0)
  `SPSM_ASSERT(a_done_out, (state_q == S_DONE && out_free) |=> out_valid_q)

endmodule
